>>> hdl/scs1a_pkg.sv
// ============================================================================
// scs1a_pkg: shared types, codes and keymap for the scan code set 1 decoder
// Holds the key code constants, the keymap table and the structs that pass
// between the decoder's modules.
// ============================================================================
package scs1a_pkg;

  localparam int ByteW = 8;
  localparam int CharW = 7;
  localparam int RowAddrW = 6;

  localparam logic [ByteW-1:0] CodePrefix = 8'hE0;
  localparam logic [ByteW-1:0] CodeLimit  = 8'h3B;
  localparam logic [ByteW-1:0] KeyLCtrl   = 8'h1D;
  localparam logic [ByteW-1:0] KeyLShift  = 8'h2A;
  localparam logic [ByteW-1:0] KeyRShift  = 8'h36;
  localparam logic [ByteW-1:0] KeyAlt     = 8'h38;
  localparam logic [ByteW-1:0] KeyCaps    = 8'h3A;
  localparam logic [ByteW-1:0] KeyLastDigit = 8'h0E;

  // One keymap row: the plain character and the shifted character.
  typedef struct packed {
    logic [CharW-1:0] plain;
    logic [CharW-1:0] shifted;
  } kmap_row_t;

  // A scan code waiting in the decode stage.
  typedef struct packed {
    logic             ext;
    logic [ByteW-1:0] code;
  } scan_item_t;

  // What the decode stage reports to the pipeline control.
  typedef struct packed {
    logic             emit;
    logic [CharW-1:0] ascii_char;
    logic             ctrl_held;
    logic             alt_held;
  } dec_result_t;

  // Keymap contents. Rows for modifier keys and unused codes are all zero.
  function automatic kmap_row_t keymap_row(input logic [RowAddrW-1:0] addr);
    kmap_row_t row;
    row = '{plain: 7'h00, shifted: 7'h00};
    case (addr)
      6'd1:  row = '{plain: 7'h1B, shifted: 7'h1B};
      6'd2:  row = '{plain: 7'h31, shifted: 7'h21};
      6'd3:  row = '{plain: 7'h32, shifted: 7'h40};
      6'd4:  row = '{plain: 7'h33, shifted: 7'h23};
      6'd5:  row = '{plain: 7'h34, shifted: 7'h24};
      6'd6:  row = '{plain: 7'h35, shifted: 7'h25};
      6'd7:  row = '{plain: 7'h36, shifted: 7'h5E};
      6'd8:  row = '{plain: 7'h37, shifted: 7'h26};
      6'd9:  row = '{plain: 7'h38, shifted: 7'h2A};
      6'd10: row = '{plain: 7'h39, shifted: 7'h28};
      6'd11: row = '{plain: 7'h30, shifted: 7'h29};
      6'd12: row = '{plain: 7'h2D, shifted: 7'h5F};
      6'd13: row = '{plain: 7'h3D, shifted: 7'h2B};
      6'd14: row = '{plain: 7'h08, shifted: 7'h08};
      6'd15: row = '{plain: 7'h09, shifted: 7'h09};
      6'd16: row = '{plain: 7'h71, shifted: 7'h51};
      6'd17: row = '{plain: 7'h77, shifted: 7'h57};
      6'd18: row = '{plain: 7'h65, shifted: 7'h45};
      6'd19: row = '{plain: 7'h72, shifted: 7'h52};
      6'd20: row = '{plain: 7'h74, shifted: 7'h54};
      6'd21: row = '{plain: 7'h79, shifted: 7'h59};
      6'd22: row = '{plain: 7'h75, shifted: 7'h55};
      6'd23: row = '{plain: 7'h69, shifted: 7'h49};
      6'd24: row = '{plain: 7'h6F, shifted: 7'h4F};
      6'd25: row = '{plain: 7'h70, shifted: 7'h50};
      6'd26: row = '{plain: 7'h5B, shifted: 7'h7B};
      6'd27: row = '{plain: 7'h5D, shifted: 7'h7D};
      6'd28: row = '{plain: 7'h0D, shifted: 7'h0D};
      6'd30: row = '{plain: 7'h61, shifted: 7'h41};
      6'd31: row = '{plain: 7'h73, shifted: 7'h53};
      6'd32: row = '{plain: 7'h64, shifted: 7'h44};
      6'd33: row = '{plain: 7'h66, shifted: 7'h46};
      6'd34: row = '{plain: 7'h67, shifted: 7'h47};
      6'd35: row = '{plain: 7'h68, shifted: 7'h48};
      6'd36: row = '{plain: 7'h6A, shifted: 7'h4A};
      6'd37: row = '{plain: 7'h6B, shifted: 7'h4B};
      6'd38: row = '{plain: 7'h6C, shifted: 7'h4C};
      6'd39: row = '{plain: 7'h3B, shifted: 7'h3A};
      6'd40: row = '{plain: 7'h27, shifted: 7'h22};
      6'd41: row = '{plain: 7'h60, shifted: 7'h7E};
      6'd43: row = '{plain: 7'h5C, shifted: 7'h7C};
      6'd44: row = '{plain: 7'h7A, shifted: 7'h5A};
      6'd45: row = '{plain: 7'h78, shifted: 7'h58};
      6'd46: row = '{plain: 7'h63, shifted: 7'h43};
      6'd47: row = '{plain: 7'h76, shifted: 7'h56};
      6'd48: row = '{plain: 7'h62, shifted: 7'h42};
      6'd49: row = '{plain: 7'h6E, shifted: 7'h4E};
      6'd50: row = '{plain: 7'h6D, shifted: 7'h4D};
      6'd51: row = '{plain: 7'h2C, shifted: 7'h3C};
      6'd52: row = '{plain: 7'h2E, shifted: 7'h3E};
      6'd53: row = '{plain: 7'h2F, shifted: 7'h3F};
      6'd55: row = '{plain: 7'h2A, shifted: 7'h2A};
      6'd57: row = '{plain: 7'h20, shifted: 7'h20};
      default: row = '{plain: 7'h00, shifted: 7'h00};
    endcase
    return row;
  endfunction

endpackage

>>> hdl/scs1a_in_if.sv
// ============================================================================
// scs1a_in_if: scan byte channel
// Valid/ready channel that carries one raw scan code byte per beat.
// ============================================================================
interface scs1a_in_if;
  logic                           valid;
  logic                           ready;
  logic [scs1a_pkg::ByteW-1:0]    scan_byte;

  modport source (output valid, output scan_byte, input ready);
  modport sink (input valid, input scan_byte, output ready);
endinterface

>>> hdl/scs1a_out_if.sv
// ============================================================================
// scs1a_out_if: decoded character channel
// Valid/ready channel that carries one character and the modifier flags.
// ============================================================================
interface scs1a_out_if;
  logic                           valid;
  logic                           ready;
  logic [scs1a_pkg::CharW-1:0]    ascii_char;
  logic                           ctrl_held;
  logic                           alt_held;

  modport source (output valid, output ascii_char, output ctrl_held, output alt_held,
                  input ready);
  modport sink (input valid, input ascii_char, input ctrl_held, input alt_held,
                output ready);
endinterface

>>> hdl/scancode_set1_to_ascii_unit.sv
// ============================================================================
// scancode_set1_to_ascii_unit: scan code set 1 to ASCII decoder
// Turns raw keyboard bytes into characters tagged with the ctrl and alt state.
// ============================================================================
// The unit takes one set 1 scan code byte per beat on in_beat and delivers at
// most one character per byte on out_beat. It accepts a byte every cycle as
// long as characters drain. The keymap ROM is read at the edge that takes the
// byte, and the decoded character is loaded into the output register once the
// decode stage retires it, so each character passes the ROM register and then
// the output register before it shows on out_beat. When a character waits
// in the output register with out_beat.ready low, a following byte that also
// makes a character holds in the decode stage and in_beat.ready drops until
// the output register frees; bytes that make no character keep flowing. A 0xE0
// prefix never produces a character: it only marks the next byte as extended.
// Break codes release ctrl, shift and alt; make codes of modifiers set them,
// and caps lock toggles on each make. Every character carries the ctrl and alt
// state seen when it was decoded. Unknown codes are dropped silently.
module scancode_set1_to_ascii_unit (
  input  logic         clk,
  input  logic         rst_n,
  scs1a_in_if.sink     in_beat,
  scs1a_out_if.source  out_beat
);

  // Prefix tracking happens at the input, since it depends on bytes alone.
  logic ext_pending_r;

  // Decode stage: the byte whose keymap row is being read.
  logic                   s1_valid_r;
  scs1a_pkg::scan_item_t  s1_item_r;
  scs1a_pkg::kmap_row_t   s1_row;
  scs1a_pkg::dec_result_t dec;

  // Output register, which lets a new byte enter while a character waits.
  logic                          out_valid_r;
  logic [scs1a_pkg::CharW-1:0]   out_char_r;
  logic                          out_ctrl_r;
  logic                          out_alt_r;

  logic in_fire, out_free, s1_go, is_prefix;

  assign out_free  = !out_valid_r || out_beat.ready;
  // A decoded item that makes no character never needs the output register.
  assign s1_go     = s1_valid_r && (!dec.emit || out_free);
  assign in_beat.ready = !s1_valid_r || s1_go;
  assign in_fire   = in_beat.valid && in_beat.ready;
  assign is_prefix = (in_beat.scan_byte == scs1a_pkg::CodePrefix);

  // The ROM only loads when a byte is taken, so its row holds during a stall.
  scs1a_rom u_rom (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr (in_beat.scan_byte[scs1a_pkg::RowAddrW-1:0]),
    .rd_row  (s1_row)
  );

  scs1a_dec u_dec (
    .clk    (clk),
    .rst_n  (rst_n),
    .item   (s1_item_r),
    .row    (s1_row),
    .retire (s1_go),
    .result (dec)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_pending_r <= 1'b0;
      s1_valid_r    <= 1'b0;
    end else begin
      if (in_fire) begin
        // A repeated prefix keeps the flag set; any other byte clears it.
        ext_pending_r <= is_prefix;
        s1_valid_r    <= !is_prefix;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.ext  <= ext_pending_r;
      s1_item_r.code <= in_beat.scan_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && dec.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_beat.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && dec.emit) begin
      out_char_r <= dec.ascii_char;
      out_ctrl_r <= dec.ctrl_held;
      out_alt_r  <= dec.alt_held;
    end
  end

  assign out_beat.valid      = out_valid_r;
  assign out_beat.ascii_char = out_char_r;
  assign out_beat.ctrl_held  = out_ctrl_r;
  assign out_beat.alt_held   = out_alt_r;

endmodule

>>> hdl/scs1a_rom.sv
// ============================================================================
// scs1a_rom: keymap ROM
// Synchronous ROM of 64 rows, addressed by the low six bits of the code; read
// data is registered on a read enable and holds until the next one.
// ============================================================================
module scs1a_rom (
  input  logic                              clk,
  input  logic                              rd_en,
  input  logic [scs1a_pkg::RowAddrW-1:0]    rd_addr,
  output scs1a_pkg::kmap_row_t              rd_row
);

  localparam int Depth = 2 ** scs1a_pkg::RowAddrW;

  scs1a_pkg::kmap_row_t rom_mem [Depth];
  scs1a_pkg::kmap_row_t rd_row_r;

  // The table is fixed, so the array is built from the package function.
  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      rom_mem[i] = scs1a_pkg::keymap_row(scs1a_pkg::RowAddrW'(i));
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_row_r <= rom_mem[rd_addr];
    end
  end

  assign rd_row = rd_row_r;

endmodule

>>> hdl/scs1a_dec.sv
// ============================================================================
// scs1a_dec: modifier state and character decode
// Holds the ctrl, shift, alt and caps lock flags, picks the keymap column and
// updates the flags when the pipeline retires an item.
// ============================================================================
module scs1a_dec (
  input  logic                  clk,
  input  logic                  rst_n,
  input  scs1a_pkg::scan_item_t item,
  input  scs1a_pkg::kmap_row_t  row,
  input  logic                  retire,
  output scs1a_pkg::dec_result_t result
);

  logic ctrl_r, shift_r, alt_r, caps_r;
  logic ctrl_nxt, shift_nxt, alt_nxt, caps_nxt;

  logic [scs1a_pkg::ByteW-1:0] code;
  logic [6:0]                  low7;
  logic                        brk, ext, known, shift_only, col;
  logic                        is_ctrl, is_shift, is_alt, is_caps;
  logic [scs1a_pkg::CharW-1:0] ch;

  assign code = item.code;
  assign ext  = item.ext;
  assign brk  = code[7];
  assign low7 = code[6:0];

  always_comb begin
    // Ctrl, alt and shift match with the break bit removed; caps lock only as a make.
    is_ctrl  = (low7 == scs1a_pkg::KeyLCtrl[6:0]);
    is_alt   = (low7 == scs1a_pkg::KeyAlt[6:0]);
    is_shift = !ext && ((low7 == scs1a_pkg::KeyLShift[6:0]) ||
                        (low7 == scs1a_pkg::KeyRShift[6:0]));
    is_caps  = !ext && !brk && (code == scs1a_pkg::KeyCaps);

    if (ext) begin
      known = (code == scs1a_pkg::KeyAlt) || (code == scs1a_pkg::KeyLCtrl);
    end else begin
      known = (code != '0) && (code < scs1a_pkg::CodeLimit);
    end

    // Digits and punctuation follow shift only; letters follow shift XOR caps.
    shift_only = !ext && ((code < scs1a_pkg::KeyLastDigit) ||
                 (code == 8'h1A) || (code == 8'h1B) || (code == 8'h27) ||
                 (code == 8'h28) || (code == 8'h29) || (code == 8'h2B) ||
                 (code == 8'h33) || (code == 8'h34) || (code == 8'h35));
    col = shift_only ? shift_r : (shift_r ^ caps_r);
    ch  = col ? row.shifted : row.plain;

    ctrl_nxt  = ctrl_r;
    shift_nxt = shift_r;
    alt_nxt   = alt_r;
    caps_nxt  = caps_r;

    result.emit       = 1'b0;
    result.ascii_char = ch;
    result.ctrl_held  = ctrl_r;
    result.alt_held   = alt_r;

    if (brk) begin
      if (is_ctrl) begin
        ctrl_nxt = 1'b0;
      end else if (is_shift) begin
        shift_nxt = 1'b0;
      end else if (is_alt) begin
        alt_nxt = 1'b0;
      end
    end else if (known) begin
      if (ch != '0) begin
        result.emit = 1'b1;
      end else if (is_ctrl) begin
        ctrl_nxt = 1'b1;
      end else if (is_shift) begin
        shift_nxt = 1'b1;
      end else if (is_alt) begin
        alt_nxt = 1'b1;
      end else if (is_caps) begin
        caps_nxt = !caps_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r  <= 1'b0;
      shift_r <= 1'b0;
      alt_r   <= 1'b0;
      caps_r  <= 1'b0;
    end else if (retire) begin
      ctrl_r  <= ctrl_nxt;
      shift_r <= shift_nxt;
      alt_r   <= alt_nxt;
      caps_r  <= caps_nxt;
    end
  end

endmodule
